// ===== rtl/core/pat_pkg.sv =====
// pat_pkg: widths, reset values, register indexes and shared types
// of the proximity activity tracker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pat_pkg;

  localparam int unsigned ChanW    = 3;
  localparam int unsigned DistW    = 13;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TmoW     = 16;
  localparam int unsigned SpeedW   = 8;
  localparam int unsigned PhaseW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ProdW    = DistW + SpeedW;
  localparam int unsigned CntW     = $clog2(SpeedW);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegNearLimit  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFarLimit   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegChangeThr  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIdleTmo    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSlowSpeed  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFastSpeed  = 3'd5;

  // reset values
  localparam logic [DistW-1:0]  NearLimitRst = 13'd50;
  localparam logic [DistW-1:0]  FarLimitRst  = 13'd200;
  localparam logic [DistW-1:0]  ChangeThrRst = 13'd5;
  localparam logic [TmoW-1:0]   IdleTmoRst   = 16'd100;
  localparam logic [SpeedW-1:0] SlowSpeedRst = 8'd20;
  localparam logic [SpeedW-1:0] FastSpeedRst = 8'd250;

  typedef struct packed {
    logic              active;
    logic [TimeW-1:0]  last_time;
    logic [DistW-1:0]  prev_dist;
    logic [PhaseW-1:0] phase;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/pat_if.sv =====
// pat_in_if and pat_out_if: valid/ready channels for samples and results
// depends on pat_pkg
`timescale 1ns / 1ps
`default_nettype none
interface pat_in_if;
  import pat_pkg::*;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] channel;
  logic [DistW-1:0] range_mm;
  logic [TimeW-1:0] now_ms;

  modport source (output valid, channel, range_mm, now_ms, input ready);
  modport sink   (input valid, channel, range_mm, now_ms, output ready);
endinterface

interface pat_out_if;
  import pat_pkg::*;
  logic              valid;
  logic              ready;
  logic [ChanW-1:0]  out_channel;
  logic              active;
  logic [SpeedW-1:0] speed;
  logic [PhaseW-1:0] phase;

  modport source (output valid, out_channel, active, speed, phase, input ready);
  modport sink   (input valid, out_channel, active, speed, phase, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pat_ctrl.sv =====
// pat_ctrl: sequencing state machine of the tracker, drives datapath commands
// depends on pat_pkg
`timescale 1ns / 1ps
`default_nettype none
module pat_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pat_pkg::cmd_t  cmd_o,
  input  pat_pkg::stat_t stat_i
);
  import pat_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   slot_free;

  assign slot_free   = !out_vld_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = S_DONE;
      end
      S_DONE: begin
        // hold the finished request until the output register is free
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ready_i) out_vld_d = 1'b0;
    if (cmd_o.commit) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_vld_q || out_ready_i))
    else $error("commit while output register busy");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_vld_q)
    else $error("committed result not presented");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while one in flight");

endmodule
`default_nettype wire

// ===== rtl/core/pat_datapath.sv =====
// pat_datapath: config registers, channel state memory, activity logic,
// speed map with multiplier and radix-2 divider; depends on pat_pkg
`timescale 1ns / 1ps
`default_nettype none
module pat_datapath #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pat_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pat_pkg::CfgDataW-1:0]   cfg_data_i,
  input  pat_pkg::cmd_t                  cmd_i,
  output pat_pkg::stat_t                 stat_o,
  input  logic [pat_pkg::ChanW-1:0]      channel_i,
  input  logic [pat_pkg::DistW-1:0]      range_mm_i,
  input  logic [pat_pkg::TimeW-1:0]      now_ms_i,
  output logic [pat_pkg::ChanW-1:0]      out_channel_o,
  output logic                           active_o,
  output logic [pat_pkg::SpeedW-1:0]     speed_o,
  output logic [pat_pkg::PhaseW-1:0]     phase_o
);
  import pat_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration
  logic [DistW-1:0]  near_q, far_q, thr_q;
  logic [TmoW-1:0]   tmo_q;
  logic [SpeedW-1:0] slow_q, fast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= NearLimitRst;
      far_q  <= FarLimitRst;
      thr_q  <= ChangeThrRst;
      tmo_q  <= IdleTmoRst;
      slow_q <= SlowSpeedRst;
      fast_q <= FastSpeedRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegNearLimit: near_q <= cfg_data_i[DistW-1:0];
        RegFarLimit:  far_q  <= cfg_data_i[DistW-1:0];
        RegChangeThr: thr_q  <= cfg_data_i[DistW-1:0];
        RegIdleTmo:   tmo_q  <= cfg_data_i[TmoW-1:0];
        RegSlowSpeed: slow_q <= cfg_data_i[SpeedW-1:0];
        RegFastSpeed: fast_q <= cfg_data_i[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  // channel state memory, entries read as zero until first written
  entry_t              mem_q [CHANNELS];
  logic [CHANNELS-1:0] vld_q;
  entry_t              rd_q, ent;
  logic                rd_vld_q;

  logic [IdxW-1:0]  idx_q;
  logic             inr_q;
  logic [ChanW-1:0] ch_q;
  logic [DistW-1:0] dist_q;
  logic [TimeW-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_q   <= mem_q[IdxW'(channel_i)];
      idx_q  <= IdxW'(channel_i);
      inr_q  <= (32'(channel_i) < CHANNELS);
      ch_q   <= channel_i;
      dist_q <= range_mm_i;
      now_q  <= now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.capture) rd_vld_q <= vld_q[IdxW'(channel_i)];
      if (cmd_i.commit && inr_q) vld_q[idx_q] <= 1'b1;
    end
  end

  assign ent = rd_vld_q ? rd_q : '0;

  // activity and clamp
  logic [TimeW-1:0]  elapsed;
  logic [DistW-1:0]  dist_chg;
  logic              act_d, act_q;
  logic [TimeW-1:0]  time_d, time_q;
  logic [DistW-1:0]  off_q, den_q;
  logic [SpeedW-1:0] mag_q;
  logic              neg_q, unord_q;

  always_comb begin
    elapsed  = now_q - ent.last_time;
    dist_chg = (dist_q >= ent.prev_dist) ? dist_q - ent.prev_dist
                                         : ent.prev_dist - dist_q;
    act_d  = ent.active;
    time_d = ent.last_time;
    if (dist_q < far_q) begin
      act_d  = 1'b1;
      time_d = now_q;
    end else if (elapsed > TimeW'(tmo_q)) begin
      act_d = 1'b0;
    end
    if (dist_chg > thr_q) begin
      act_d  = 1'b1;
      time_d = now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      act_q   <= act_d;
      time_q  <= time_d;
      if (dist_q < near_q)     off_q <= '0;
      else if (dist_q > far_q) off_q <= far_q - near_q;
      else                     off_q <= dist_q - near_q;
      neg_q   <= (fast_q < slow_q);
      mag_q   <= (fast_q < slow_q) ? slow_q - fast_q : fast_q - slow_q;
      unord_q <= (far_q <= near_q);
      den_q   <= far_q - near_q;
    end
  end

  // divider: quotient never exceeds the speed span, so the top bits of the
  // product already sit below the divisor and only SpeedW steps are needed
  logic [ProdW-1:0]  prod;
  logic [DistW-1:0]  rem_q;
  logic [SpeedW-1:0] qsh_q;
  logic [CntW-1:0]   cnt_q;
  logic [DistW:0]    trial;
  logic              ge;

  assign prod  = ProdW'(off_q) * ProdW'(mag_q);
  assign trial = {rem_q, qsh_q[SpeedW-1]} - {1'b0, den_q};
  assign ge    = !trial[DistW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rem_q <= prod[ProdW-1:SpeedW];
      qsh_q <= prod[SpeedW-1:0];
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? trial[DistW-1:0] : {rem_q[DistW-2:0], qsh_q[SpeedW-1]};
      qsh_q <= {qsh_q[SpeedW-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign stat_o.div_done = (cnt_q == CntW'(SpeedW - 1));

  // final speed, phase update and write back
  logic [SpeedW-1:0] speed_w, step;
  logic [PhaseW-1:0] phase_new;

  always_comb begin
    if (unord_q)    speed_w = slow_q;
    else if (neg_q) speed_w = slow_q - qsh_q;
    else            speed_w = slow_q + qsh_q;
    step      = act_q ? speed_w : {1'b0, slow_q[SpeedW-1:1]};
    phase_new = ent.phase + PhaseW'(step);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && inr_q) begin
      mem_q[idx_q] <= '{active: act_q, last_time: time_q, prev_dist: dist_q,
                        phase: phase_new};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_channel_o <= ch_q;
      active_o      <= inr_q & act_q;
      speed_o       <= inr_q ? speed_w : '0;
      phase_o       <= inr_q ? phase_new : '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/proximity_activity_tracker_core.sv =====
// proximity_activity_tracker_core: top level, joins pat_ctrl and pat_datapath
// depends on pat_pkg, pat_in_if, pat_out_if
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    channel, range_mm, now_ms
//   out_ch    out  valid/ready    out_channel, active, speed, phase
//   cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i (write only)
//
// one request at a time: it passes evaluate, multiply, an 8-step restoring
// divider and commit before its result sits in the output register; the next
// request is taken the cycle after the commit, not before.
// a result waiting on out_ch does not block acceptance; a second finished
// result waits in the final state until the output register frees up.
// reset clears all channel state through per-channel valid bits, no sweep.
`timescale 1ns / 1ps
`default_nettype none
module proximity_activity_tracker_core #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pat_in_if.sink                       in_ch,
  pat_out_if.source                    out_ch,
  input  logic                         cfg_we_i,
  input  logic [pat_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pat_pkg::CfgDataW-1:0] cfg_data_i
);
  import pat_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  pat_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .channel_i     (in_ch.channel),
    .range_mm_i    (in_ch.range_mm),
    .now_ms_i      (in_ch.now_ms),
    .out_channel_o (out_ch.out_channel),
    .active_o      (out_ch.active),
    .speed_o       (out_ch.speed),
    .phase_o       (out_ch.phase)
  );

endmodule
`default_nettype wire
